// ===== sv/etc_pkg.sv =====
package etc_pkg;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  endpoint_kind;
    logic        is_valid;
    logic [63:0] address_high;
    logic [63:0] address_low;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_DNS  = 2'd0,
    KIND_IPV4 = 2'd1,
    KIND_IPV6 = 2'd2
  } kind_t;

  // colon run tracker codes
  typedef enum logic [1:0] {
    RUN_NONE = 2'd0,
    RUN_LEAD = 2'd1,
    RUN_ONE  = 2'd2,
    RUN_GAP  = 2'd3
  } run_t;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam int unsigned GROUPS  = 8;
  localparam logic [6:0] LABEL_MAX = 7'd63;

  // summary of a finished name, handed from front to back
  typedef struct packed {
    logic        bad;
    logic        saw_colon;
    logic        is_quad;
    logic        dns_ok;
    logic        hex_ok;
    logic        gap_seen;
    logic [3:0]  gap_position;
    logic [3:0]  n_groups;
    logic [127:0] groups;
    logic        quad_ok;
    logic [31:0] quad_addr;
  } summary_t;

endpackage

// ===== sv/endpoint_text_classifier.sv =====
// Endpoint name classifier: takes a name one byte per accepted item, the
// final byte marked by last_byte, and gives one result item per name with its
// kind (DNS, IPv4, IPv6), a validity flag and the decoded address. A byte is
// taken every cycle; the front checker closes a name on its last byte and
// hands a summary through a two-entry queue to the back stage, which expands
// the IPv6 gap and registers the result.
// Input stalls only when the queue is full.
module endpoint_text_classifier
  import etc_pkg::*;
#(
  parameter int MAX_LENGTH = 255
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic take, done, full, avail, pop;
  summary_t sum_in, sum_out;

  assign in_ready = !full;
  assign take = in_valid && in_ready;

  etc_front #(.MAX_LENGTH(MAX_LENGTH)) u_front (
    .clk, .rst, .in_item(in_data), .take, .done, .summary(sum_in)
  );

  etc_queue u_queue (
    .clk, .rst, .push(done), .push_data(sum_in), .full,
    .pop, .not_empty(avail), .pop_data(sum_out)
  );

  etc_back u_back (
    .clk, .rst, .avail, .summary(sum_out), .pop,
    .out_valid, .out_ready, .out_item(out_data)
  );

endmodule

// ===== sv/etc_front.sv =====
module etc_front
  import etc_pkg::*;
#(
  parameter int MAX_LENGTH = 255
) (
  input  logic     clk,
  input  logic     rst,
  input  in_item_t in_item,
  input  logic     take,
  output logic     done,
  output summary_t summary
);

  localparam int CW = $clog2(MAX_LENGTH + 2);

  logic [CW-1:0] byte_count;
  logic saw_colon, only_digits_dots, saw_dot, saw_bad_byte;
  logic [6:0] label_len;
  logic [7:0] prev_byte;
  logic hostname_ok;
  logic [1:0] quad_part, quad_digits;
  logic [8:0] quad_value;
  logic quad_lead_zero, quad_ok;
  logic [7:0] quad_octets [4];
  logic [15:0] hex_groups [GROUPS];
  logic [3:0] hex_group_count, gap_position;
  logic [15:0] hex_current;
  logic [2:0] hex_digits;
  logic gap_seen, hex_ok;
  run_t colon_run;

  logic [7:0] c;
  logic is_dig, is_alnum, hex_valid;
  logic [3:0] hex_d;

  // next values of per-name state
  logic [CW-1:0] byte_count_next;
  logic saw_colon_next, only_next, saw_dot_next, bad_next;
  logic [6:0] label_len_next;
  logic hostname_ok_next;
  logic [1:0] quad_part_next, quad_digits_next;
  logic [8:0] quad_value_next;
  logic quad_lead_zero_next, quad_ok_next;
  logic q_wr;
  logic [3:0] hex_group_count_next, gap_position_next;
  logic [15:0] hex_current_next;
  logic [2:0] hex_digits_next;
  logic gap_seen_next, hex_ok_next, h_wr;
  run_t colon_run_next;

  assign c = in_item.char_byte;
  assign is_dig = c >= 8'h30 && c <= 8'h39;
  assign is_alnum = is_dig || (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);

  // hex digit decode
  always_comb begin
    hex_valid = 1'b1;
    hex_d = 4'd0;
    if (is_dig) hex_d = c[3:0];
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      hex_d = 4'(c[2:0] + 3'd1) + 4'd8;
    else hex_valid = 1'b0;
  end

  // ipv6 checker
  always_comb begin
    hex_group_count_next = hex_group_count;
    gap_position_next = gap_position;
    hex_current_next = hex_current;
    hex_digits_next = hex_digits;
    gap_seen_next = gap_seen;
    hex_ok_next = hex_ok;
    colon_run_next = colon_run;
    h_wr = 1'b0;
    if (hex_ok) begin
      if (c == CH_COLON) begin
        if (hex_digits != 3'd0) begin
          if (hex_group_count[3]) hex_ok_next = 1'b0;
          else begin
            h_wr = 1'b1;
            hex_group_count_next = hex_group_count + 4'd1;
            hex_digits_next = 3'd0;
            hex_current_next = 16'd0;
          end
          colon_run_next = RUN_ONE;
        end else if (colon_run == RUN_LEAD) begin
          gap_seen_next = 1'b1;
          gap_position_next = 4'd0;
          colon_run_next = RUN_GAP;
        end else if (colon_run == RUN_ONE) begin
          if (gap_seen) hex_ok_next = 1'b0;
          else begin
            gap_seen_next = 1'b1;
            gap_position_next = hex_group_count;
            colon_run_next = RUN_GAP;
          end
        end else if (colon_run == RUN_NONE && byte_count == '0) begin
          colon_run_next = RUN_LEAD;
        end else begin
          hex_ok_next = 1'b0;
        end
      end else if (!hex_valid || colon_run == RUN_LEAD || hex_digits >= 3'd4 ||
                   (hex_digits == 3'd0 && hex_group_count[3])) begin
        hex_ok_next = 1'b0;
      end else begin
        hex_current_next = {hex_current[11:0], hex_d};
        hex_digits_next = hex_digits + 3'd1;
        colon_run_next = RUN_NONE;
      end
    end
  end

  // ipv4 checker
  always_comb begin
    logic [9:0] v;
    v = 10'(quad_value) * 10'd10 + {6'd0, c[3:0]};
    quad_part_next = quad_part;
    quad_digits_next = quad_digits;
    quad_value_next = quad_value;
    quad_lead_zero_next = quad_lead_zero;
    quad_ok_next = quad_ok;
    q_wr = 1'b0;
    if (quad_ok) begin
      if (is_dig) begin
        if (quad_digits == 2'd3 || (quad_digits != 2'd0 && quad_lead_zero))
          quad_ok_next = 1'b0;
        else begin
          if (quad_digits == 2'd0) quad_lead_zero_next = c[3:0] == 4'd0;
          // at most two prior digits, so value below 100 here
          quad_value_next = v[8:0];
          if (v > 10'd255) quad_ok_next = 1'b0;
          else quad_digits_next = quad_digits + 2'd1;
        end
      end else if (c == CH_DOT) begin
        if (quad_digits == 2'd0 || quad_part == 2'd3) quad_ok_next = 1'b0;
        else begin
          q_wr = 1'b1;
          quad_part_next = quad_part + 2'd1;
          quad_digits_next = 2'd0;
          quad_value_next = 9'd0;
        end
      end else begin
        quad_ok_next = 1'b0;
      end
    end
  end

  // dns checker and general flags
  always_comb begin
    hostname_ok_next = hostname_ok;
    label_len_next = label_len;
    if (c == CH_NUL || c == CH_STAR) hostname_ok_next = 1'b0;
    else if (c == CH_DOT) begin
      if (label_len == 7'd0 || label_len > LABEL_MAX || prev_byte == CH_DASH)
        hostname_ok_next = 1'b0;
      label_len_next = 7'd0;
    end else begin
      if (!(is_alnum || c == CH_DASH) || (label_len == 7'd0 && c == CH_DASH))
        hostname_ok_next = 1'b0;
      if (label_len < 7'd64) label_len_next = label_len + 7'd1;
    end
    bad_next = saw_bad_byte || c == CH_NUL;
    saw_colon_next = saw_colon || c == CH_COLON;
    saw_dot_next = saw_dot || c == CH_DOT;
    only_next = only_digits_dots && (c == CH_DOT || is_dig);
    byte_count_next = byte_count;
    if (byte_count <= CW'(MAX_LENGTH)) byte_count_next = byte_count + CW'(1);
  end

  // finishing of the name on its last byte
  always_comb begin
    logic hok, fin_wr;
    logic [3:0] cnt;
    logic [127:0] g;
    hok = hex_ok_next;
    cnt = hex_group_count_next;
    fin_wr = 1'b0;
    if (hok) begin
      if (hex_digits_next != 3'd0) begin
        if (cnt[3]) hok = 1'b0;
        else begin
          fin_wr = 1'b1;
          cnt = cnt + 4'd1;
        end
      end else if (colon_run_next != RUN_GAP) hok = 1'b0;
    end
    for (int i = 0; i < GROUPS; i++) begin
      g[127-16*i -: 16] = hex_groups[i];
      if ((h_wr && hex_group_count[2:0] == 3'(i)) ||
          (fin_wr && hex_group_count_next[2:0] == 3'(i)))
        g[127-16*i -: 16] = h_wr ? hex_current : hex_current_next;
    end
    summary.bad = bad_next || byte_count_next > CW'(MAX_LENGTH);
    summary.saw_colon = saw_colon_next;
    summary.is_quad = only_next && saw_dot_next;
    summary.dns_ok = hostname_ok_next && label_len_next != 7'd0 &&
                     label_len_next <= LABEL_MAX && c != CH_DASH;
    summary.hex_ok = hok;
    summary.gap_seen = gap_seen_next;
    summary.gap_position = gap_position_next;
    summary.n_groups = cnt;
    summary.groups = g;
    summary.quad_ok = quad_ok_next && quad_digits_next != 2'd0 && quad_part_next == 2'd3;
    summary.quad_addr = {q_wr && quad_part == 2'd0 ? quad_value[7:0] : quad_octets[0],
                         q_wr && quad_part == 2'd1 ? quad_value[7:0] : quad_octets[1],
                         q_wr && quad_part == 2'd2 ? quad_value[7:0] : quad_octets[2],
                         quad_value_next[7:0]};
  end

  assign done = take && in_item.last_byte;

  // group and octet stores
  always_ff @(posedge clk) begin
    if (take && h_wr) hex_groups[hex_group_count[2:0]] <= hex_current;
    if (take && q_wr) quad_octets[quad_part] <= quad_value[7:0];
  end

  // per-name control state, cleared after each last byte
  always_ff @(posedge clk) begin
    if (rst || done) begin
      byte_count <= '0;
      saw_colon <= 1'b0; only_digits_dots <= 1'b1; saw_dot <= 1'b0;
      saw_bad_byte <= 1'b0; label_len <= 7'd0; prev_byte <= 8'd0;
      hostname_ok <= 1'b1; quad_part <= 2'd0; quad_digits <= 2'd0;
      quad_value <= 9'd0; quad_lead_zero <= 1'b0; quad_ok <= 1'b1;
      hex_group_count <= 4'd0; hex_current <= 16'd0; hex_digits <= 3'd0;
      gap_position <= 4'd0; gap_seen <= 1'b0; hex_ok <= 1'b1;
      colon_run <= RUN_NONE;
    end else if (take) begin
      byte_count <= byte_count_next;
      saw_colon <= saw_colon_next; only_digits_dots <= only_next;
      saw_dot <= saw_dot_next; saw_bad_byte <= bad_next;
      label_len <= label_len_next; prev_byte <= c;
      hostname_ok <= hostname_ok_next; quad_part <= quad_part_next;
      quad_digits <= quad_digits_next; quad_value <= quad_value_next;
      quad_lead_zero <= quad_lead_zero_next; quad_ok <= quad_ok_next;
      hex_group_count <= hex_group_count_next; hex_current <= hex_current_next;
      hex_digits <= hex_digits_next; gap_position <= gap_position_next;
      gap_seen <= gap_seen_next; hex_ok <= hex_ok_next;
      colon_run <= colon_run_next;
    end
  end

endmodule

// ===== sv/etc_queue.sv =====
module etc_queue
  import etc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  summary_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output summary_t pop_data
);

  // two-entry queue of name summaries
  summary_t slots [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0; rd_ptr <= 1'b0; count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== sv/etc_back.sv =====
module etc_back
  import etc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      avail,
  input  summary_t  summary,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  out_item_t res;

  // expand the summary into the result item
  always_comb begin
    logic [3:0] missing, idx;
    logic [127:0] full_addr;
    res = '0;
    missing = summary.gap_seen ? 4'd8 - summary.n_groups : 4'd0;
    full_addr = '0;
    for (int i = 0; i < GROUPS; i++) begin
      idx = 4'(i) - missing;
      if (!summary.gap_seen || 4'(i) < summary.gap_position)
        full_addr[127-16*i -: 16] = summary.groups[127-16*i -: 16];
      else if (4'(i) < summary.gap_position + missing)
        full_addr[127-16*i -: 16] = 16'd0;
      else
        full_addr[127-16*i -: 16] = summary.groups[127-16*idx[2:0] -: 16];
    end
    if (summary.bad) begin
      res.endpoint_kind = KIND_DNS;
    end else if (summary.saw_colon) begin
      res.endpoint_kind = KIND_IPV6;
      res.is_valid = summary.hex_ok && (summary.gap_seen ? !summary.n_groups[3]
                                                         : summary.n_groups == 4'd8);
      if (res.is_valid) {res.address_high, res.address_low} = full_addr;
    end else if (summary.is_quad) begin
      res.endpoint_kind = KIND_IPV4;
      res.is_valid = summary.quad_ok;
      if (res.is_valid) res.address_low = {32'd0, summary.quad_addr};
    end else begin
      res.endpoint_kind = KIND_DNS;
      res.is_valid = summary.dns_ok;
    end
  end

  // output register
  assign pop = avail && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (pop) out_item <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (pop) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

endmodule
